// ----- rtl/core/rau_pkg.sv -----
`timescale 1ns / 1ps
package rau_pkg;

  localparam int DATA_W        = 32;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int DEN_W         = DATA_W - 1;
  localparam int DEFAULT_WIDTH = 32;
  localparam int ACT_W         = 3;

  localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;

  typedef logic [PROD_W-1:0] wide_t;

endpackage

// ----- rtl/core/rational_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// A zero numerator or denominator is resolved in the check state; otherwise the
// result passes through the bit-serial binary gcd (one shift or subtract per cycle)
// and two restoring divisions on one shared divider.
// Throughput: one word at a time; busy stays high until the result is issued.
// Reset is asynchronous and active low; the result strobe cannot be stalled.
module rational_arithmetic_unit #(
  parameter int WIDTH = rau_pkg::DEFAULT_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [rau_pkg::ACT_W-1:0]       action_i,
  input  logic signed [rau_pkg::DATA_W-1:0] a_num_i,
  input  logic signed [rau_pkg::DATA_W-1:0] a_den_i,
  input  logic signed [rau_pkg::DATA_W-1:0] b_num_i,
  input  logic signed [rau_pkg::DATA_W-1:0] b_den_i,
  output logic                            res_valid_o,
  output logic signed [rau_pkg::DATA_W-1:0] res_num_o,
  output logic [rau_pkg::DEN_W-1:0]       res_den_o,
  output logic                            is_infinite_o,
  output logic                            overflow_o
);
  import rau_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_COMB, S_CHECK, S_GCD, S_DIVN, S_DIVD, S_OUT}
    state_e;

  localparam wide_t HALF    = wide_t'(1) << (WIDTH - 1);
  localparam wide_t POS_MAX = HALF - 1'b1;
  localparam wide_t NEG_MIN = ~HALF + 1'b1;

  state_e             state_q;
  logic [ACT_W-1:0]   act_q;
  logic [DATA_W-1:0]  an_q, ad_q, bn_q, bd_q;
  logic               an_s_q, ad_s_q, bn_s_q, bd_s_q;
  logic [1:0]         mcnt_q;
  wide_t              p_q [4];
  wide_t              n_q, d_q, g_q, rn_q;
  logic               neg_q;
  logic               res_valid_q, inf_q, ovf_q;
  logic [DATA_W-1:0]  res_num_q;
  logic [DEN_W-1:0]   res_den_q;

  // One shared 32x32 multiplier, result registered into p_q.
  logic [DATA_W-1:0]  mx, my;
  wide_t              prod;
  always_comb begin
    case (mcnt_q)
      2'd0:    begin mx = an_q; my = bd_q; end
      2'd1:    begin mx = bn_q; my = ad_q; end
      2'd2:    begin mx = ad_q; my = bd_q; end
      default: begin mx = an_q; my = bn_q; end
    endcase
  end
  assign prod = wide_t'(mx) * wide_t'(my);

  // Signed combination of the products.
  logic  s0, s1, s2, s3, sb, sx, sd;
  wide_t comb_n, comb_d;
  always_comb begin
    sb = (act_q == ACT_SUB) ? ~bn_s_q : bn_s_q;
    s0 = (an_s_q ^ bd_s_q) && (p_q[0] != '0);
    s1 = (sb ^ ad_s_q) && (p_q[1] != '0);
    s2 = (ad_s_q ^ bd_s_q) && (p_q[2] != '0);
    s3 = (an_s_q ^ bn_s_q) && (p_q[3] != '0);
    case (act_q)
      ACT_ADD, ACT_SUB: begin
        if (s0 == s1) begin
          comb_n = p_q[0] + p_q[1];
          sx     = s0;
        end else if (p_q[0] >= p_q[1]) begin
          comb_n = p_q[0] - p_q[1];
          sx     = s0;
        end else begin
          comb_n = p_q[1] - p_q[0];
          sx     = s1;
        end
        comb_d = p_q[2];
        sd     = s2;
      end
      ACT_MUL: begin
        comb_n = p_q[3];
        sx     = s3;
        comb_d = p_q[2];
        sd     = s2;
      end
      ACT_DIV: begin
        comb_n = p_q[0];
        sx     = (an_s_q ^ bd_s_q);
        comb_d = p_q[1];
        sd     = (ad_s_q ^ bn_s_q) && (p_q[1] != '0);
      end
      default: begin
        comb_n = wide_t'(an_q);
        sx     = an_s_q;
        comb_d = wide_t'(ad_q);
        sd     = ad_s_q && (ad_q != '0);
      end
    endcase
  end

  logic  gcd_start, gcd_done, div_start, div_done;
  wide_t gcd_g, div_a, div_q;

  assign gcd_start = (state_q == S_CHECK) && (n_q != '0) && (d_q != '0);
  assign div_a     = (state_q == S_GCD) ? n_q : d_q;
  assign div_start = ((state_q == S_GCD) && gcd_done) || ((state_q == S_DIVN) && div_done);

  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .x_i     (n_q),
    .y_i     (d_q),
    .done_o  (gcd_done),
    .g_o     (gcd_g)
  );

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  ((state_q == S_GCD) ? gcd_g : g_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  wide_t sat_num;
  logic  fits;
  assign sat_num = neg_q ? NEG_MIN : POS_MAX;
  assign fits    = (div_q <= POS_MAX) && (neg_q ? (rn_q <= HALF) : (rn_q <= POS_MAX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mcnt_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            act_q   <= action_i;
            an_s_q  <= a_num_i[DATA_W-1];
            ad_s_q  <= a_den_i[DATA_W-1];
            bn_s_q  <= b_num_i[DATA_W-1];
            bd_s_q  <= b_den_i[DATA_W-1];
            an_q    <= a_num_i[DATA_W-1] ? -a_num_i : a_num_i;
            ad_q    <= a_den_i[DATA_W-1] ? -a_den_i : a_den_i;
            bn_q    <= b_num_i[DATA_W-1] ? -b_num_i : b_num_i;
            bd_q    <= b_den_i[DATA_W-1] ? -b_den_i : b_den_i;
            mcnt_q  <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          p_q[mcnt_q] <= prod;
          mcnt_q      <= mcnt_q + 1'b1;
          if (mcnt_q == 2'd3) state_q <= S_COMB;
        end
        S_COMB: begin
          n_q     <= comb_n;
          d_q     <= comb_d;
          neg_q   <= sx != sd;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (n_q == '0) begin
            res_num_q   <= '0;
            res_den_q   <= DEN_W'(1);
            inf_q       <= 1'b0;
            ovf_q       <= 1'b0;
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else if (d_q == '0) begin
            res_num_q   <= sat_num[DATA_W-1:0];
            res_den_q   <= '0;
            inf_q       <= 1'b1;
            ovf_q       <= 1'b0;
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_GCD;
          end
        end
        S_GCD: begin
          if (gcd_done) begin
            g_q     <= gcd_g;
            state_q <= S_DIVN;
          end
        end
        S_DIVN: begin
          if (div_done) begin
            rn_q    <= div_q;
            state_q <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (div_done) state_q <= S_OUT;
        end
        S_OUT: begin
          // The divider output still holds the reduced denominator here.
          if (fits) begin
            res_num_q <= neg_q ? (~rn_q[DATA_W-1:0] + 1'b1) : rn_q[DATA_W-1:0];
            res_den_q <= div_q[DEN_W-1:0];
            inf_q     <= 1'b0;
            ovf_q     <= 1'b0;
          end else begin
            res_num_q <= sat_num[DATA_W-1:0];
            res_den_q <= '0;
            inf_q     <= 1'b1;
            ovf_q     <= 1'b1;
          end
          res_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign res_valid_o   = res_valid_q;
  assign res_num_o     = res_num_q;
  assign res_den_o     = res_den_q;
  assign is_infinite_o = inf_q;
  assign overflow_o    = ovf_q;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");
  a_strobe_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("result strobe longer than one cycle");
  a_inf_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (is_infinite_o == (res_den_o == '0))) else $error("infinity flag mismatch");
  a_ovf_inf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && overflow_o) |-> is_infinite_o) else $error("overflow without saturation");

endmodule

// ----- rtl/core/rau_gcd.sv -----
`timescale 1ns / 1ps
module rau_gcd (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  rau_pkg::wide_t   x_i,
  input  rau_pkg::wide_t   y_i,
  output logic             done_o,
  output rau_pkg::wide_t   g_o
);
  import rau_pkg::*;

  localparam int K_W = $clog2(PROD_W);

  typedef enum logic [1:0] {G_IDLE, G_TWOS, G_XODD, G_LOOP} gstate_e;

  gstate_e      state_q;
  wide_t        x_q, y_q, g_q;
  logic [K_W-1:0] k_q;
  logic         done_q;

  // Binary gcd: strip common factors of two, then subtract and shift.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      done_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        G_IDLE: begin
          if (start_i) begin
            x_q     <= x_i;
            y_q     <= y_i;
            k_q     <= '0;
            state_q <= G_TWOS;
          end
        end
        G_TWOS: begin
          if (!x_q[0] && !y_q[0]) begin
            x_q <= x_q >> 1;
            y_q <= y_q >> 1;
            k_q <= k_q + 1'b1;
          end else begin
            state_q <= G_XODD;
          end
        end
        G_XODD: begin
          if (!x_q[0]) x_q <= x_q >> 1;
          else state_q <= G_LOOP;
        end
        G_LOOP: begin
          if (y_q == '0) begin
            g_q     <= x_q << k_q;
            done_q  <= 1'b1;
            state_q <= G_IDLE;
          end else if (!y_q[0]) begin
            y_q <= y_q >> 1;
          end else if (x_q > y_q) begin
            x_q <= y_q;
            y_q <= x_q - y_q;
          end else begin
            y_q <= y_q - x_q;
          end
        end
        default: state_q <= G_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign g_o    = g_q;

endmodule

// ----- rtl/core/rau_div.sv -----
`timescale 1ns / 1ps
module rau_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  rau_pkg::wide_t   dividend_i,
  input  rau_pkg::wide_t   divisor_i,
  output logic             done_o,
  output rau_pkg::wide_t   quot_o
);
  import rau_pkg::*;

  localparam int CNT_W = $clog2(PROD_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  wide_t            quo_q, rem_q, dsr_q;
  logic [PROD_W:0]  rem_sh, trial;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_q, quo_q[PROD_W-1]};
  assign trial  = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (start_i) begin
          busy_q <= 1'b1;
          quo_q  <= dividend_i;
          rem_q  <= '0;
          dsr_q  <= divisor_i;
          cnt_q  <= '0;
        end
      end else begin
        if (!trial[PROD_W]) begin
          rem_q <= trial[PROD_W-1:0];
          quo_q <= {quo_q[PROD_W-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[PROD_W-1:0];
          quo_q <= {quo_q[PROD_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(PROD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
